// File: sv/mbe_pkg.sv
`default_nettype none
// ============================================================================
// mbe_pkg: shared types and constants of the escape-time evaluator
// Register indexes, reset values, the configuration bundle and the
// saturation helper used by the datapath.
// ============================================================================
package mbe_pkg;

    // Grid points along each axis; larger indexes are clamped to the last one.
    localparam int GRID_SIZE = 1024;

    localparam int FRAC_BITS = 28;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ITER_CAP  = 3'd0;
    localparam logic [2:0] CFG_ESC_LIMIT = 3'd1;
    localparam logic [2:0] CFG_RE_ORIGIN = 3'd2;
    localparam logic [2:0] CFG_RE_STEP   = 3'd3;
    localparam logic [2:0] CFG_IM_ORIGIN = 3'd4;
    localparam logic [2:0] CFG_IM_STEP   = 3'd5;

    // Reset values.
    localparam logic [15:0]        RST_ITER_CAP  = 16'd1000;
    localparam logic [30:0]        RST_ESC_LIMIT = 31'd1073741824;
    localparam logic signed [31:0] RST_RE_ORIGIN = -32'sd536870912;
    localparam logic [30:0]        RST_RE_STEP   = 31'd655360;
    localparam logic signed [31:0] RST_IM_ORIGIN = -32'sd536870912;
    localparam logic [30:0]        RST_IM_STEP   = 31'd1048576;

    typedef struct packed {
        logic [15:0]        iter_cap;
        logic [30:0]        esc_limit;
        logic signed [31:0] re_origin;
        logic [30:0]        re_step;
        logic signed [31:0] im_origin;
        logic [30:0]        im_step;
    } t_cfg;

    // Clamp a 48-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > 48'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: sv/mbe_cfg.sv
`default_nettype none
// ============================================================================
// mbe_cfg: configuration register file
// Holds the six programmable registers and presents them as one bundle.
// ============================================================================
module mbe_cfg import mbe_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iter_cap  <= RST_ITER_CAP;
            r_cfg.esc_limit <= RST_ESC_LIMIT;
            r_cfg.re_origin <= RST_RE_ORIGIN;
            r_cfg.re_step   <= RST_RE_STEP;
            r_cfg.im_origin <= RST_IM_ORIGIN;
            r_cfg.im_step   <= RST_IM_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ITER_CAP:  r_cfg.iter_cap  <= i_cfg_data[15:0];
                CFG_ESC_LIMIT: r_cfg.esc_limit <= i_cfg_data[30:0];
                CFG_RE_ORIGIN: r_cfg.re_origin <= i_cfg_data;
                CFG_RE_STEP:   r_cfg.re_step   <= i_cfg_data[30:0];
                CFG_IM_ORIGIN: r_cfg.im_origin <= i_cfg_data;
                CFG_IM_STEP:   r_cfg.im_step   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: sv/mbe_mul.sv
`default_nettype none
// ============================================================================
// mbe_mul: shared signed multiplier
// One 32x32 signed multiply per cycle with a registered 64-bit product.
// ============================================================================
module mbe_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [63:0]      o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// File: sv/mandelbrot_escape_time.sv
`default_nettype none
// ============================================================================
// mandelbrot_escape_time: escape-time evaluator for one grid point
// Maps a row/column index to a point c in signed Q4.28, iterates
// z = z*z + c from zero and reports how many updates ran before |z|^2
// passed the escape limit (minus one), capped at the iteration cap minus one.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  -------------------------
//  in        input      i_in_valid / o_in_ready     row_index, col_index
//  out       output     o_out_valid / i_out_ready   row_echo, col_echo,
//                                                   iteration_count
//  cfg       input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// Each point runs as steps on the single shared 32x32 multiplier. Setup
// forms c from two products, real part first. The first z update is z = c
// and needs no product; after it, each step issues zr*zr, zi*zi and zr*zi
// one after another, tests |z|^2 against the limit and, unless z escaped
// or the cap is reached, forms the next z. The number of z updates run is
// the escape iteration plus one, at most the iteration cap; a zero cap
// skips the products and the test. The result sits in an output register,
// so the next point is accepted while a finished result still waits for the
// downstream side; a point that finishes while that register is still full
// holds in its final state until the register drains. Reset is synchronous,
// active low, and restores the sequencer, output flag and config registers.
// ============================================================================
module mandelbrot_escape_time import mbe_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [9:0]  i_row_index,
    input  wire logic [9:0]  i_col_index,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [9:0]       o_row_echo,
    output logic [9:0]       o_col_echo,
    output logic [15:0]      o_iteration_count,

    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;  // waiting for a point
    localparam logic [3:0] ST_CRE  = 4'd1;  // issue real step product
    localparam logic [3:0] ST_CIM  = 4'd2;  // form c_re, issue imaginary product
    localparam logic [3:0] ST_CSAT = 4'd3;  // form c_im, first update is z = c
    localparam logic [3:0] ST_UPD  = 4'd4;  // form next z from the products
    localparam logic [3:0] ST_MRR  = 4'd5;  // issue zr*zr
    localparam logic [3:0] ST_MII  = 4'd6;  // issue zi*zi
    localparam logic [3:0] ST_MRI  = 4'd7;  // issue zr*zi, test the magnitude
    localparam logic [3:0] ST_FIN  = 4'd8;  // hand the count to the output register

    t_cfg w_cfg;

    mbe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    logic [3:0]         r_state, n_state;
    logic [9:0]         r_row, r_col;
    logic signed [31:0] r_cr, r_ci;
    logic signed [31:0] r_zr, r_zi;
    logic signed [63:0] r_rr, r_ii;
    logic [15:0]        r_k;

    logic               r_out_valid;
    logic [9:0]         r_out_row, r_out_col;
    logic [15:0]        r_out_count;

    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod;

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Indexes past the grid are clamped to the last grid point.
    logic [9:0]  w_row_cl, w_col_cl;
    assign w_row_cl = ({7'd0, r_row} >= 17'(GRID_SIZE)) ? 10'(GRID_SIZE - 1) : r_row;
    assign w_col_cl = ({7'd0, r_col} >= 17'(GRID_SIZE)) ? 10'(GRID_SIZE - 1) : r_col;

    // The multiplier computes step * (2*index + 1); half of it is the offset.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_CRE: begin
                w_mul_a = signed'({1'b0, w_cfg.re_step});
                w_mul_b = signed'({21'd0, w_row_cl, 1'b1});
            end
            ST_CIM: begin
                w_mul_a = signed'({1'b0, w_cfg.im_step});
                w_mul_b = signed'({21'd0, w_col_cl, 1'b1});
            end
            ST_MRR: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            ST_MII: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            ST_MRI: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
            default: ;
        endcase
    end

    // Coordinate: origin plus floor of the registered product over two.
    logic signed [31:0] w_coord_re, w_coord_im;
    assign w_coord_re = sat32(48'(w_cfg.re_origin) + 48'(w_prod >>> 1));
    assign w_coord_im = sat32(48'(w_cfg.im_origin) + 48'(w_prod >>> 1));

    // Next z: real from (rr - ii) / 2^28, imaginary from ri / 2^27, both
    // floored. In ST_UPD the multiplier output holds zr*zi. The kept high
    // bits are read as signed so that negative values extend correctly.
    logic signed [63:0] w_diff;
    logic signed [31:0] w_next_zr, w_next_zi;
    assign w_diff    = r_rr - r_ii;
    assign w_next_zr = sat32(48'($signed(w_diff[63:FRAC_BITS])) + 48'(r_cr));
    assign w_next_zi = sat32(48'($signed(w_prod[63:FRAC_BITS-1])) + 48'(r_ci));

    // Escape test in ST_MRI: r_rr holds zr*zr, the multiplier output zi*zi.
    // Both are non-negative and at most 2^62, so the sum fits unsigned 64 bits.
    logic [63:0] w_mag, w_bound;
    logic        w_escape, w_at_cap;
    assign w_mag    = $unsigned(r_rr) + $unsigned(w_prod);
    assign w_bound  = {5'd0, w_cfg.esc_limit, 28'd0};
    assign w_escape = w_mag > w_bound;
    assign w_at_cap = r_k == (w_cfg.iter_cap - 16'd1);

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_CRE;
            ST_CRE:  n_state = ST_CIM;
            ST_CIM:  n_state = ST_CSAT;
            ST_CSAT: n_state = (w_cfg.iter_cap == 16'd0) ? ST_FIN : ST_MRR;
            ST_UPD:  n_state = ST_MRR;
            ST_MRR:  n_state = ST_MII;
            ST_MII:  n_state = ST_MRI;
            ST_MRI:  n_state = (w_escape || w_at_cap) ? ST_FIN : ST_UPD;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_row <= i_row_index;
                r_col <= i_col_index;
            end
            ST_CIM: r_cr <= w_coord_re;
            ST_CSAT: begin
                // The first update from z = 0 gives z = c exactly.
                r_ci <= w_coord_im;
                r_zr <= r_cr;
                r_zi <= w_coord_im;
                r_k  <= 16'd0;
            end
            ST_UPD: begin
                r_zr <= w_next_zr;
                r_zi <= w_next_zi;
            end
            ST_MII: r_rr <= w_prod;
            ST_MRI: begin
                r_ii <= w_prod;
                if (!w_escape && !w_at_cap) begin
                    r_k <= r_k + 16'd1;
                end
            end
            default: ;
        endcase
    end

    // Output register. An escape on the final allowed update and a point that
    // never escapes both report the current count, which is then cap minus one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_count <= r_k;
        end
    end

    assign o_in_ready        = r_state == ST_IDLE;
    assign o_out_valid       = r_out_valid;
    assign o_row_echo        = r_out_row;
    assign o_col_echo        = r_out_col;
    assign o_iteration_count = r_out_count;

endmodule
`default_nettype wire

// File: bench/tb_mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_mandelbrot_escape_time: self-checking bench for the escape-time evaluator
// Drives grid points through the valid/ready input channel under a series of
// register settings. Each accepted point is scored by a bit-exact Q4.28
// escape-count predictor; every result transfer is checked, field by field,
// against the oldest score due. Both sides idle at random until the last test.
// ============================================================================
module tb_mandelbrot_escape_time import mbe_pkg::*;;

    // One scored grid point, in the order the block must return it.
    typedef struct {
        logic [9:0]  row;
        logic [9:0]  col;
        logic [15:0] count;
    } t_point_score;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [9:0]  i_row_index;
    logic [9:0]  i_col_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [9:0]  o_row_echo;
    logic [9:0]  o_col_echo;
    logic [15:0] o_iteration_count;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // Register values as the predictor believes them to be.
    t_cfg         cur_settings;
    // Scores of accepted points whose results have not come back yet.
    t_point_score scores_due[$];
    int           mismatches;
    // Random idling on both channels; cleared for the closing stretch.
    bit           gaps_on;

    mandelbrot_escape_time i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_row_index       (i_row_index),
        .i_col_index       (i_col_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_row_echo        (o_row_echo),
        .o_col_echo        (o_col_echo),
        .o_iteration_count (o_iteration_count),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The slowest correct run is dominated by one point held at the 65535
    // iteration cap plus a handful of points at the default cap of 1000.
    // The random phases keep caps small, so the whole run stays well inside
    // this timeout.
    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Clamp a wide signed value into the signed 32-bit Q4.28 range.
    function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Grid index to axis coordinate: origin + floor(step * (index + 1/2)).
    function automatic logic signed [31:0] grid_coord(input logic signed [31:0] origin,
                                                      input logic [30:0] step,
                                                      input logic [9:0] idx);
        logic [63:0]        lane;
        logic [63:0]        offset;
        logic signed [63:0] base;
        lane   = (idx >= GRID_SIZE) ? 64'(GRID_SIZE - 1) : 64'(idx);
        offset = (64'(step) * (2 * lane + 64'd1)) >> 1;
        base   = origin;
        return clamp_q(base + $signed(offset));
    endfunction

    // Number of z updates before |z|^2 passes the limit, minus one.
    function automatic logic [15:0] predict_escape(input t_cfg s,
                                                   input logic [9:0] row,
                                                   input logic [9:0] col);
        logic signed [63:0] cr, ci, zr, zi, rr, ii, ri, nr, ni;
        logic [63:0]        mag, bound;
        int                 k;
        cr    = grid_coord(s.re_origin, s.re_step, row);
        ci    = grid_coord(s.im_origin, s.im_step, col);
        zr    = 0;
        zi    = 0;
        bound = 64'(s.esc_limit) << FRAC_BITS;
        if (s.iter_cap == 16'd0) begin
            return 16'd0;
        end
        for (k = 0; k < int'(s.iter_cap); k++) begin
            rr  = zr * zr;
            ii  = zi * zi;
            ri  = zr * zi;
            // Arithmetic shifts of signed values round toward minus infinity.
            nr  = ((rr - ii) >>> FRAC_BITS) + cr;
            ni  = (ri >>> (FRAC_BITS - 1)) + ci;
            zr  = clamp_q(nr);
            zi  = clamp_q(ni);
            mag = zr * zr + zi * zi;
            if (mag > bound) begin
                return 16'(k);
            end
        end
        return s.iter_cap - 16'd1;
    endfunction

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Writes all six registers on consecutive cycles. The upper bits of the
    // data word beyond each register's width carry random junk, which the
    // block must ignore. Called at a falling edge with nothing outstanding.
    task automatic apply_settings(input t_cfg s);
        logic [31:0] words [6];
        logic [2:0]  slots [6];
        words[0] = {16'($urandom), s.iter_cap};
        words[1] = {1'($urandom), s.esc_limit};
        words[2] = s.re_origin;
        words[3] = {1'($urandom), s.re_step};
        words[4] = s.im_origin;
        words[5] = {1'($urandom), s.im_step};
        slots[0] = CFG_ITER_CAP;
        slots[1] = CFG_ESC_LIMIT;
        slots[2] = CFG_RE_ORIGIN;
        slots[3] = CFG_RE_STEP;
        slots[4] = CFG_IM_ORIGIN;
        slots[5] = CFG_IM_STEP;
        for (int n = 0; n < 6; n++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= slots[n];
            i_cfg_data  <= words[n];
            @(negedge i_clk);
        end
        i_cfg_we     <= 1'b0;
        cur_settings  = s;
    endtask

    // Offers one grid point and returns at the falling edge after its
    // transfer. Valid is left high so that the next point can follow at once;
    // the caller lowers it by way of drain_points.
    task automatic send_point(input logic [9:0] row, input logic [9:0] col);
        t_point_score score;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_row_index <= row;
        i_col_index <= col;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        score.row   = row;
        score.col   = col;
        score.count = predict_escape(cur_settings, row, col);
        scores_due.push_back(score);
        @(negedge i_clk);
    endtask

    // Withdraws the input and waits until every accepted point has reported.
    // Each point yields exactly one result, so the block is then idle.
    task automatic drain_points();
        i_in_valid <= 1'b0;
        while (scores_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // A random register setting, biased toward the interesting part of the
    // plane and toward small caps so that the random phases stay quick.
    function automatic t_cfg random_settings();
        t_cfg s;
        case ($urandom_range(0, 9))
            0:       s.iter_cap = 16'd0;
            1:       s.iter_cap = 16'($urandom_range(1, 3));
            2:       s.iter_cap = 16'($urandom_range(64, 160));
            default: s.iter_cap = 16'($urandom_range(4, 40));
        endcase
        case ($urandom_range(0, 5))
            0:       s.esc_limit = 31'($urandom);
            1:       s.esc_limit = 31'd0;
            default: s.esc_limit = 31'($urandom_range(32'h1000_0000, 32'h4000_0000));
        endcase
        if ($urandom_range(0, 4) == 0) begin
            // Anywhere on the plane, steps of any size; mostly saturated.
            s.re_origin = $urandom;
            s.im_origin = $urandom;
            s.re_step   = 31'($urandom);
            s.im_step   = 31'($urandom);
        end else begin
            // A window from about -2.5..-0.5 on the real axis and -1.5..0 on
            // the imaginary axis, spanning up to eight units over the grid.
            s.re_origin = -$signed(32'($urandom_range(32'h0800_0000, 32'h2800_0000)));
            s.im_origin = -$signed(32'($urandom_range(0, 32'h1800_0000)));
            s.re_step   = 31'($urandom_range(0, 32'h0020_0000));
            s.im_step   = 31'($urandom_range(0, 32'h0020_0000));
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Downstream side: random back-pressure in bursts.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left   = $urandom_range(0, 5);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every output transfer is matched with the oldest score.
    // ------------------------------------------------------------------------
    initial begin
        t_point_score want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (scores_due.size() == 0) begin
                    $display("%0t: result with nothing outstanding: row %0d col %0d count %0d",
                             $time, o_row_echo, o_col_echo, o_iteration_count);
                    mismatches++;
                end else begin
                    want = scores_due.pop_front();
                    if (o_row_echo !== want.row) begin
                        $display("%0t: row_echo expected %0d, got %0d",
                                 $time, want.row, o_row_echo);
                        mismatches++;
                    end
                    if (o_col_echo !== want.col) begin
                        $display("%0t: col_echo expected %0d, got %0d",
                                 $time, want.col, o_col_echo);
                        mismatches++;
                    end
                    if (o_iteration_count !== want.count) begin
                        $display("%0t: iteration_count at (%0d,%0d) expected %0d, got %0d",
                                 $time, want.row, want.col, want.count, o_iteration_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Points under the reset settings: two opposite grid corners, alternating
    // bit patterns in the indexes, and two points that never escape.
    task automatic test_reset_defaults();
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'h2AA, 10'h155);
        send_point(10'h155, 10'h2AA);
        // c, about -0.749 + 0.002i, lies by the period-two bulb and runs to the cap.
        send_point(10'd512, 10'd512);
        // Close to the origin, inside the main cardioid.
        send_point(10'd800, 10'd512);
        drain_points();
    endtask

    // A zero cap, a cap of one and the largest cap.
    task automatic test_iteration_cap_extremes();
        t_cfg s;
        s = cur_settings;
        s.iter_cap = 16'd0;
        apply_settings(s);
        send_point(10'd0, 10'd1023);
        send_point(10'd512, 10'd512);
        drain_points();

        s.iter_cap = 16'd1;
        apply_settings(s);
        send_point(10'd1023, 10'd0);
        send_point(10'd512, 10'd512);
        drain_points();

        // c = 0 keeps z at zero for the full 65535 updates, even with the
        // widest escape limit.
        s.iter_cap  = 16'hFFFF;
        s.esc_limit = 31'h7FFF_FFFF;
        s.re_origin = 32'sd0;
        s.re_step   = 31'd0;
        s.im_origin = 32'sd0;
        s.im_step   = 31'd0;
        apply_settings(s);
        send_point(10'd77, 10'd901);
        drain_points();
    endtask

    // With c = 1.0 the orbit runs 1, 2, 5: |z|^2 equals the 4.0 limit after
    // the second update and passes it on the third.
    task automatic test_escape_on_last_update();
        t_cfg s;
        s.esc_limit = RST_ESC_LIMIT;
        s.re_origin = 32'sh1000_0000;
        s.re_step   = 31'd0;
        s.im_origin = 32'sd0;
        s.im_step   = 31'd0;
        // Escape exactly on the last allowed update.
        s.iter_cap = 16'd3;
        apply_settings(s);
        send_point(10'd3, 10'd5);
        drain_points();
        // Cap reached one update short of escape.
        s.iter_cap = 16'd2;
        apply_settings(s);
        send_point(10'd3, 10'd5);
        drain_points();
        // Escape with room to spare.
        s.iter_cap = 16'd4;
        apply_settings(s);
        send_point(10'd3, 10'd5);
        drain_points();
        // A zero limit lets the very first nonzero z escape.
        s.esc_limit = 31'd0;
        apply_settings(s);
        send_point(10'd3, 10'd5);
        drain_points();
    endtask

    // Coordinates pushed past the top of the Q4.28 range and held at its bottom.
    task automatic test_coordinate_saturation();
        t_cfg s;
        s.iter_cap  = 16'd20;
        s.esc_limit = 31'h7FFF_FFFF;
        s.re_origin = 32'sh7FFF_FFFF;
        s.re_step   = 31'h7FFF_FFFF;
        s.im_origin = 32'sh8000_0000;
        s.im_step   = 31'd0;
        apply_settings(s);
        send_point(10'd1023, 10'd1023);
        send_point(10'd0, 10'd0);
        drain_points();
        // Real part at the bottom of the range, imaginary part clipped high.
        s.re_origin = 32'sh8000_0000;
        s.re_step   = 31'd0;
        s.im_origin = 32'sh7FFF_FFFF;
        s.im_step   = 31'h7FFF_FFFF;
        apply_settings(s);
        send_point(10'd1023, 10'd1023);
        send_point(10'd512, 10'd1);
        drain_points();
    endtask

    // Random points under a fresh random setting per phase.
    task automatic test_random_grid(input int phases, input int points_per_phase);
        for (int p = 0; p < phases; p++) begin
            apply_settings(random_settings());
            for (int n = 0; n < points_per_phase; n++) begin
                send_point(10'($urandom), 10'($urandom));
            end
            drain_points();
        end
    endtask

    // Back-to-back traffic with no idling on either side, under the reset
    // window but with a small cap.
    task automatic test_steady_stream(input int points);
        t_cfg s;
        gaps_on    = 1'b0;
        s.iter_cap  = 16'd24;
        s.esc_limit = RST_ESC_LIMIT;
        s.re_origin = RST_RE_ORIGIN;
        s.re_step   = RST_RE_STEP;
        s.im_origin = RST_IM_ORIGIN;
        s.im_step   = RST_IM_STEP;
        apply_settings(s);
        for (int n = 0; n < points; n++) begin
            send_point(10'($urandom), 10'($urandom));
        end
        drain_points();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_row_index  = '0;
        i_col_index  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_ITER_CAP;
        i_cfg_data   = '0;
        mismatches   = 0;
        gaps_on      = 1'b1;
        cur_settings.iter_cap  = RST_ITER_CAP;
        cur_settings.esc_limit = RST_ESC_LIMIT;
        cur_settings.re_origin = RST_RE_ORIGIN;
        cur_settings.re_step   = RST_RE_STEP;
        cur_settings.im_origin = RST_IM_ORIGIN;
        cur_settings.im_step   = RST_IM_STEP;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_iteration_cap_extremes();
        test_escape_on_last_update();
        test_coordinate_saturation();
        test_random_grid(8, 68);
        test_steady_stream(60);

        // Give the block time to show any stray result.
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/mbe_pkg.sv
sv/mbe_cfg.sv
sv/mbe_mul.sv
sv/mandelbrot_escape_time.sv
bench/tb_mandelbrot_escape_time.sv
